### rtl/fkd_pkg.sv
package fkd_pkg;

    // Phase codes of the key sequencer.
    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_MODE_SEEN = 4'd1;
    localparam logic [3:0] PH_MODE_HELD = 4'd2;
    localparam logic [3:0] PH_UP_SEEN   = 4'd3;
    localparam logic [3:0] PH_UP_HELD   = 4'd4;
    localparam logic [3:0] PH_UP_LONG   = 4'd5;
    localparam logic [3:0] PH_DN_SEEN   = 4'd6;
    localparam logic [3:0] PH_DN_HELD   = 4'd7;
    localparam logic [3:0] PH_DN_LONG   = 4'd8;
    localparam logic [3:0] PH_OK_SEEN   = 4'd9;
    localparam logic [3:0] PH_OK_HELD   = 4'd10;

    // Event codes on the result channel.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_MODE    = 3'd1;
    localparam logic [2:0] EV_UP      = 3'd2;
    localparam logic [2:0] EV_UP_LONG = 3'd3;
    localparam logic [2:0] EV_DN      = 3'd4;
    localparam logic [2:0] EV_DN_LONG = 3'd5;
    localparam logic [2:0] EV_OK      = 3'd6;

    // Threshold value after reset.
    localparam logic [7:0] LONG_PRESS_RESET = 8'd20;

    // Key levels of one scan tick, active low.
    typedef struct packed {
        logic mode_key_low;
        logic up_key_low;
        logic down_key_low;
        logic ok_key_low;
    } t_keys;

    // Outcome of one sequencer step.
    typedef struct packed {
        logic [3:0] phase;
        logic [8:0] held;
        logic [2:0] key_event;
    } t_step;

endpackage

### rtl/fkd_key_if.sv
interface fkd_key_if;
    logic valid;
    logic ready;
    logic mode_key_low;
    logic up_key_low;
    logic down_key_low;
    logic ok_key_low;

    modport source (output valid, output mode_key_low, output up_key_low,
                    output down_key_low, output ok_key_low, input ready);
    modport sink   (input valid, input mode_key_low, input up_key_low,
                    input down_key_low, input ok_key_low, output ready);
endinterface

### rtl/fkd_event_if.sv
interface fkd_event_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_event;

    modport source (output valid, output key_event, input ready);
    modport sink   (input valid, input key_event, output ready);
endinterface

### rtl/fkd_step.sv
module fkd_step (
    input  logic [3:0]     i_phase,
    input  logic [8:0]     i_held,
    input  logic [7:0]     i_threshold,
    input  fkd_pkg::t_keys i_keys,
    output fkd_pkg::t_step o_step
);

    logic [8:0] held_inc;

    assign held_inc = i_held + 9'd1;

    // Priority select of the held key, then its confirm and long-press sequence.
    always_comb begin
        o_step.phase     = i_phase;
        o_step.held      = i_held;
        o_step.key_event = fkd_pkg::EV_NONE;
        if (!i_keys.mode_key_low) begin
            if (i_phase == fkd_pkg::PH_MODE_SEEN) begin
                o_step.phase     = fkd_pkg::PH_MODE_HELD;
                o_step.key_event = fkd_pkg::EV_MODE;
            end else if (i_phase != fkd_pkg::PH_MODE_HELD) begin
                o_step.phase = fkd_pkg::PH_MODE_SEEN;
            end
        end else if (!i_keys.up_key_low) begin
            if (i_phase == fkd_pkg::PH_UP_SEEN) begin
                o_step.phase     = fkd_pkg::PH_UP_HELD;
                o_step.held      = 9'd0;
                o_step.key_event = fkd_pkg::EV_UP;
            end else if (i_phase == fkd_pkg::PH_UP_HELD) begin
                o_step.held = held_inc;
                if (held_inc > {1'b0, i_threshold}) begin
                    o_step.phase     = fkd_pkg::PH_UP_LONG;
                    o_step.key_event = fkd_pkg::EV_UP_LONG;
                end
            end else if (i_phase == fkd_pkg::PH_UP_LONG) begin
                o_step.key_event = fkd_pkg::EV_UP_LONG;
            end else begin
                o_step.phase = fkd_pkg::PH_UP_SEEN;
            end
        end else if (!i_keys.down_key_low) begin
            if (i_phase == fkd_pkg::PH_DN_SEEN) begin
                o_step.phase     = fkd_pkg::PH_DN_HELD;
                o_step.held      = 9'd0;
                o_step.key_event = fkd_pkg::EV_DN;
            end else if (i_phase == fkd_pkg::PH_DN_HELD) begin
                o_step.held = held_inc;
                if (held_inc > {1'b0, i_threshold}) begin
                    o_step.phase     = fkd_pkg::PH_DN_LONG;
                    o_step.key_event = fkd_pkg::EV_DN_LONG;
                end
            end else if (i_phase == fkd_pkg::PH_DN_LONG) begin
                o_step.key_event = fkd_pkg::EV_DN_LONG;
            end else begin
                o_step.phase = fkd_pkg::PH_DN_SEEN;
            end
        end else if (!i_keys.ok_key_low) begin
            if (i_phase == fkd_pkg::PH_OK_SEEN) begin
                o_step.phase     = fkd_pkg::PH_OK_HELD;
                o_step.key_event = fkd_pkg::EV_OK;
            end else if (i_phase != fkd_pkg::PH_OK_HELD) begin
                o_step.phase = fkd_pkg::PH_OK_SEEN;
            end
        end else begin
            o_step.phase = fkd_pkg::PH_IDLE;
        end
    end

endmodule

### rtl/four_key_debounce_long_press.sv
// Four-key debounce with long press.
// i_key carries one scan tick per beat: four active-low key levels (mode, up,
// down, ok). o_event returns exactly one beat per tick with key_event: none,
// a confirmed press, or a repeating long press of up or down.
// A key must be seen on two ticks in a row before its press is reported once.
// i_cfg_we with i_cfg_data writes the long-press threshold in held ticks;
// write it only while no tick is in flight.
// A tick is taken into the input register, stepped through the sequencer into
// the result register, and then presented on o_event.
// Throughput: one tick per cycle while o_event is not stalled, set by the single
// sequencer state update between the input register and the result register.
// A stalled o_event holds its beat; the input register still takes one more
// tick, then i_key.ready drops until the result register frees.
// Reset (synchronous, active low) empties both registers, returns the
// sequencer to idle with a zero held count and loads the threshold with 20.
module four_key_debounce_long_press (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fkd_key_if.sink           i_key,
    fkd_event_if.source       o_event,
    input  logic              i_cfg_we,
    input  logic [7:0]        i_cfg_data
);

    logic                 r_in_valid;
    fkd_pkg::t_keys       r_keys;
    logic                 r_out_valid;
    logic [2:0]           r_event;
    logic [3:0]           r_phase;
    logic [8:0]           r_held;
    logic [7:0]           r_threshold;
    logic                 advance;
    logic                 step_en;
    fkd_pkg::t_keys       in_keys;
    fkd_pkg::t_step       n_step;

    // The input register moves on when the result register is empty or drained.
    assign advance     = !r_out_valid || o_event.ready;
    assign step_en     = r_in_valid && advance;
    assign i_key.ready = !r_in_valid || advance;

    assign in_keys.mode_key_low = i_key.mode_key_low;
    assign in_keys.up_key_low   = i_key.up_key_low;
    assign in_keys.down_key_low = i_key.down_key_low;
    assign in_keys.ok_key_low   = i_key.ok_key_low;

    // Threshold register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= fkd_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            r_threshold <= i_cfg_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_key.ready) begin
            r_in_valid <= i_key.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_key.valid && i_key.ready) begin
            r_keys <= in_keys;
        end
    end

    fkd_step u_step (
        .i_phase     (r_phase),
        .i_held      (r_held),
        .i_threshold (r_threshold),
        .i_keys      (r_keys),
        .o_step      (n_step)
    );

    // Sequencer state advances once per stepped tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= fkd_pkg::PH_IDLE;
            r_held  <= 9'd0;
        end else if (step_en) begin
            r_phase <= n_step.phase;
            r_held  <= n_step.held;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_event <= n_step.key_event;
        end
    end

    assign o_event.valid     = r_out_valid;
    assign o_event.key_event = r_event;

`ifndef SYNTHESIS
    // A held tick waiting for the result register is neither lost nor altered.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid && $stable(r_keys))
        else $error("input tick lost while result stalled");

    // A confirmed up or down press restarts the held count.
    a_press_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en && (n_step.key_event == fkd_pkg::EV_UP ||
                    n_step.key_event == fkd_pkg::EV_DN) |=> r_held == 9'd0)
        else $error("held count not cleared on press");

    // An up long press leaves the sequencer in the up long phase.
    a_long_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en && n_step.key_event == fkd_pkg::EV_UP_LONG
        |=> r_phase == fkd_pkg::PH_UP_LONG)
        else $error("up long press without long phase");

    // A stepped tick always produces a result beat.
    a_step_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_en |=> r_out_valid && r_event == $past(n_step.key_event))
        else $error("stepped tick gave no result beat");
`endif

endmodule
